>>> src/longest_increasing_subsequence_length_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest increasing subsequence length block
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lis assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lis assertion failed");

`endif

>>> src/lis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIS package
// Default sizes and the control part of the word that travels the cell chain.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned MaxLenDef    = 1024;
  localparam int unsigned DataWidthDef = 32;

  // Control bits carried with a value from cell to cell.
  typedef struct packed {
    logic vld;   // a word occupies this chain slot
    logic last;  // final element of the sequence
    logic done;  // value already placed in some cell
    logic app;   // value was placed by extending the table
  } lis_ctl_t;

endpackage

>>> src/lis_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIS channel interfaces
// Valid/ready channels for the incoming elements and the length results.
// ----------------------------------------------------------------------------
interface lis_in_if #(
  parameter int unsigned DW = 32
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] value;
  logic          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lis_out_if #(
  parameter int unsigned LW = 11
);
  logic          valid;
  logic          ready;
  logic [LW-1:0] length;
  logic          end_of_sequence;
  logic          overflow;

  modport source (output valid, output length, output end_of_sequence, output overflow,
                  input ready);
  modport sink   (input valid, input length, input end_of_sequence, input overflow,
                  output ready);
endinterface

>>> src/lis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIS tail cell
// Holds one tail entry, places a passing value and forwards it to the next cell.
// ----------------------------------------------------------------------------
module lis_cell #(
  parameter int unsigned DATA_WIDTH = lis_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  lis_pkg::lis_ctl_t            ctl_i,
  input  logic signed [DATA_WIDTH-1:0] key_i,
  output lis_pkg::lis_ctl_t            ctl_o,
  output logic signed [DATA_WIDTH-1:0] key_o
);
  import lis_pkg::*;

  lis_ctl_t                     ctl_d, ctl_q;
  logic                         occ_d, occ_q;
  logic signed [DATA_WIDTH-1:0] tail_d, tail_q;
  logic signed [DATA_WIDTH-1:0] key_q;

  always_comb begin
    ctl_d  = ctl_i;
    occ_d  = occ_q;
    tail_d = tail_q;
    if (ctl_i.vld && !ctl_i.done) begin
      if (!occ_q) begin
        // First empty cell reached: the table grows by one.
        tail_d    = key_i;
        occ_d     = 1'b1;
        ctl_d.done = 1'b1;
        ctl_d.app  = 1'b1;
      end else if (tail_q >= key_i) begin
        tail_d     = key_i;
        ctl_d.done = 1'b1;
      end
    end
    // The end of a sequence empties every cell it passes.
    if (ctl_i.vld && ctl_i.last) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      occ_q <= 1'b0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tail_q <= tail_d;
      key_q  <= key_i;
    end
  end

  assign ctl_o = ctl_q;
  assign key_o = key_q;

endmodule

>>> src/longest_increasing_subsequence_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest increasing subsequence length
// Patience-sorting tail table built as a systolic chain of tail cells.
// ----------------------------------------------------------------------------
// Usage: each word on in_i carries one signed element and a last flag. Every
// accepted word produces exactly one word on out_o, in order, with the strictly
// increasing subsequence length so far, an echo of last, and a sticky overflow
// flag. A word marked last ends the sequence; its result holds the final
// answer and the block then starts a fresh sequence.
// Each accepted word passes the MAX_LEN tail cells and the output register
// before out_o.valid. Throughput is one word per cycle unless the receiver
// stalls: each element walks the chain one cell per cycle, behind the
// elements accepted before it, so every cell sees the table already updated.
// Reset empties all cells and clears the length and overflow state; tail
// values themselves are not reset. When the receiver stalls with a result
// waiting, the whole chain holds and in_i.ready drops in the same cycle.
// ----------------------------------------------------------------------------
`include "longest_increasing_subsequence_length_defines.svh"

module longest_increasing_subsequence_length #(
  parameter int unsigned MAX_LEN    = lis_pkg::MaxLenDef,
  parameter int unsigned DATA_WIDTH = lis_pkg::DataWidthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lis_in_if.sink    in_i,
  lis_out_if.source out_o
);
  import lis_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_LEN + 1);

  // Chain links: slot 0 is fed from the input channel, slot MAX_LEN leaves
  // the last cell.
  lis_ctl_t                     ctl [MAX_LEN+1];
  logic signed [DATA_WIDTH-1:0] key [MAX_LEN+1];

  logic adv;

  // Sequence state, updated as each element leaves the chain.
  logic [LenW-1:0] count_d, count_q;
  logic            ovf_d, ovf_q;
  logic [LenW-1:0] cnt_new;
  logic            ovf_new;

  // Output register.
  logic            out_vld_q;
  logic [LenW-1:0] len_q;
  logic            eos_q;
  logic            ovf_out_q;

  // The chain moves whenever the output register is free or being drained.
  assign adv = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    ctl[0]      = '0;
    ctl[0].vld  = in_i.valid;
    ctl[0].last = in_i.last;
    key[0]      = $signed(in_i.value[DATA_WIDTH-1:0]);
  end

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lis_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (ctl[i]),
      .key_i (key[i]),
      .ctl_o (ctl[i+1]),
      .key_o (key[i+1])
    );
  end

  // An element that reached the end without a home found the table full.
  always_comb begin
    cnt_new = count_q + LenW'(ctl[MAX_LEN].app);
    ovf_new = ovf_q | !ctl[MAX_LEN].done;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ctl[MAX_LEN].vld) begin
      count_d = ctl[MAX_LEN].last ? '0 : cnt_new;
      ovf_d   = ctl[MAX_LEN].last ? 1'b0 : ovf_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      out_vld_q <= ctl[MAX_LEN].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ctl[MAX_LEN].vld) begin
      len_q     <= cnt_new;
      eos_q     <= ctl[MAX_LEN].last;
      ovf_out_q <= ovf_new;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.length          = len_q;
  assign out_o.end_of_sequence = eos_q;
  assign out_o.overflow        = ovf_out_q;

  // The running length never passes the table size.
  `LIS_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= LenW'(MAX_LEN))
  // A reported overflow means the table was full.
  `LIS_ASSERT_IMPL(a_ovf_full, clk_i, rst_ni, out_vld_q && ovf_out_q,
                   len_q == LenW'(MAX_LEN))
  // The end of a sequence leaves the chain and clears the running state.
  `LIS_ASSERT_NEXT(a_seq_clear, clk_i, rst_ni, adv && ctl[MAX_LEN].vld && ctl[MAX_LEN].last,
                   count_q == '0 && !ovf_q)
  // Only a placed element can have grown the table.
  `LIS_ASSERT_IMPL(a_app_done, clk_i, rst_ni, ctl[MAX_LEN].vld && ctl[MAX_LEN].app,
                   ctl[MAX_LEN].done)

endmodule

>>> test/longest_increasing_subsequence_length_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest increasing subsequence length testbench
// Drives signed elements into the tail-table chain and checks every length
// word against a patience-sorting tracker kept inside the testbench. Both
// channel sides idle at random in the first two random phases, and one long
// rising sequence fills the table to force the overflow flag.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_length_tb;
  import lis_pkg::*;

  localparam int unsigned MaxLen     = MaxLenDef;
  localparam int unsigned DataW      = DataWidthDef;
  localparam int unsigned LenW       = $clog2(MaxLen + 1);
  // Acceptance to result passes every tail cell and then the output stage.
  localparam int unsigned Latency    = MaxLen + 1;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsGoal  = 1350;

  // Shapes of the short random sequences.
  typedef enum int unsigned {
    SHAPE_SPREAD,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_CORNERS
  } seq_shape_e;

  // One expected result word.
  typedef struct packed {
    logic [LenW-1:0] length;
    logic            end_of_sequence;
    logic            overflow;
  } length_word_t;

  // Tracks the table of minimum tails exactly as the block should, and holds
  // the length words that are still due on the output channel.
  class lis_length_tracker;
    logic signed [DataW-1:0] tails [MaxLen];
    int unsigned             table_len;
    bit                      dropped;
    length_word_t            due_words [$];
    int unsigned             errors;

    function new();
      table_len = 0;
      dropped   = 1'b0;
      errors    = 0;
    endfunction

    // Called for every accepted input word.
    function void note_word(logic signed [DataW-1:0] value, logic last);
      int unsigned  pos;
      length_word_t w;
      if (table_len == 0 || value > tails[table_len-1]) begin
        if (table_len < MaxLen) begin
          tails[table_len] = value;
          table_len++;
        end else begin
          dropped = 1'b1;
        end
      end else begin
        // The last tail is >= value here, so the search stops inside the table.
        pos = 0;
        while (tails[pos] < value) pos++;
        tails[pos] = value;
      end
      w.length          = table_len[LenW-1:0];
      w.end_of_sequence = last;
      w.overflow        = dropped;
      due_words = {due_words, w};
      if (last) begin
        table_len = 0;
        dropped   = 1'b0;
      end
    endfunction

    // Called for every accepted output word.
    function void check_word(logic [LenW-1:0] length, logic eos, logic ovf);
      length_word_t w;
      if (due_words.size() == 0) begin
        $error("unexpected result word: length %0d, end_of_sequence %0b, overflow %0b",
               length, eos, ovf);
        errors++;
        return;
      end
      w = due_words.pop_front();
      if (length !== w.length) begin
        $error("length: expected %0d, actual %0d", w.length, length);
        errors++;
      end
      if (eos !== w.end_of_sequence) begin
        $error("end_of_sequence: expected %0b, actual %0b", w.end_of_sequence, eos);
        errors++;
      end
      if (ovf !== w.overflow) begin
        $error("overflow: expected %0b, actual %0b", w.overflow, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lis_in_if  #(.DW(DataW)) elem_ch ();
  lis_out_if #(.LW(LenW))  len_ch ();

  longest_increasing_subsequence_length #(
    .MAX_LEN   (MaxLen),
    .DATA_WIDTH(DataW)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (elem_ch),
    .out_o (len_ch)
  );

  lis_length_tracker tracker;
  int unsigned       words_sent;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake must not let the run go on forever.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver side. Ready is updated with a nonblocking assignment after the
  // check, so the check below sees the same ready that the block saw.
  initial begin
    len_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (len_ch.valid && len_ch.ready) begin
        tracker.check_word(len_ch.length, len_ch.end_of_sequence, len_ch.overflow);
      end
      len_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one element and returns once it has been accepted. Valid stays
  // high afterwards, so back-to-back words need no extra assignment.
  task automatic send_word(input logic [DataW-1:0] value, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      elem_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.value <= value;
    elem_ch.last  <= last;
    do @(posedge clk_i); while (!elem_ch.ready);
    tracker.note_word(value, last);
    words_sent++;
  endtask

  // Holds the sender off until every length word due has come back.
  task automatic wait_drained();
    elem_ch.valid <= 1'b0;
    while (tracker.due_words.size() != 0) @(posedge clk_i);
  endtask

  // A short sequence with random length and a random shape. Narrow values
  // give many equal elements, rising ones build deep tables.
  task automatic play_short_sequence();
    int unsigned             n;
    seq_shape_e              shape;
    logic signed [DataW-1:0] v;
    n     = $urandom_range(1, 40);
    shape = seq_shape_e'($urandom_range(0, 4));
    // Rising runs are picked with chance 7/15, each other shape with 2/15, since they reach the deepest states.
    if ($urandom_range(0, 2) == 0) shape = SHAPE_RISING;
    v = $urandom;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_SPREAD: v = $urandom;
        SHAPE_NARROW: v = $signed($urandom_range(0, 16)) - 8;
        SHAPE_RISING: begin
          if ($urandom_range(0, 7) == 0) v = v - $urandom_range(0, 400);
          else v = v + $urandom_range(0, 300);
        end
        SHAPE_FALLING: v = v - $urandom_range(0, 100);
        default: begin
          case ($urandom_range(0, 4))
            0: v = {1'b1, {(DataW-1){1'b0}}};
            1: v = {1'b0, {(DataW-1){1'b1}}};
            2: v = '1;
            3: v = '0;
            default: v = $urandom;
          endcase
        end
      endcase
      send_word(v, i == n - 1);
    end
  endtask

  // One sequence that is longer than the table: the rising part passes
  // MaxLen, so later appends are dropped and overflow must stick until last.
  // The margin above MaxLen covers the occasional repeats.
  task automatic play_table_filler();
    logic signed [DataW-1:0] v;
    v = {1'b1, {(DataW-1){1'b0}}} + $urandom_range(0, 1000);
    for (int i = 0; i < MaxLen + 64; i++) begin
      // An occasional repeat replaces the top tail instead of growing it.
      if ($urandom_range(0, 49) != 0) v = v + $urandom_range(1, 1000);
      send_word(v, 1'b0);
    end
    // With the table full, mix appends that get dropped and replacements.
    for (int i = 0; i < 9; i++) send_word($urandom, 1'b0);
    send_word({1'b0, {(DataW-1){1'b1}}}, 1'b1);
  endtask

  initial begin
    tracker       = new();
    words_sent    = 0;
    send_idle_pct = 30;
    recv_idle_pct = 69;
    rst_ni        <= 1'b0;
    elem_ch.valid <= 1'b0;
    elem_ch.value <= '0;
    elem_ch.last  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Single-element sequences at both extremes start from an
    // empty table each time.
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    // Extremes, equal elements (which must not grow the table, since the
    // count is strictly increasing) and a replacement of the first tail.
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h0000_0002, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0005, 1'b1);
    // A falling sequence keeps the length at one.
    send_word(32'd100, 1'b0);
    send_word(32'd50, 1'b0);
    send_word(32'd50, 1'b0);
    send_word(-32'sd50, 1'b1);
    // Alternating bit patterns around the sign boundary.
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h7FFF_FFFE, 1'b0);
    send_word(32'hAAAA_AAAB, 1'b0);
    send_word(32'h5555_5556, 1'b1);

    // Random phase one: a sluggish receiver.
    while (words_sent < 150) play_short_sequence();
    wait_drained();

    // Random phase two: a sluggish sender, and the table filled once.
    send_idle_pct = 69;
    recv_idle_pct = 30;
    play_table_filler();
    while (words_sent < ItemsGoal - 120) play_short_sequence();

    // Random phase three: both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_sent < ItemsGoal) play_short_sequence();

    // Let every due word arrive, then leave room for anything stray.
    elem_ch.valid <= 1'b0;
    while (tracker.due_words.size() != 0) @(posedge clk_i);
    repeat (Latency + 16) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
